[sv/prq_pkg.sv]
// shared constants and types of the priority ready-queue scheduler
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

  localparam int MAX_THREADS   = 16;
  localparam int PRIORITY_BITS = 8;

  localparam int ID_W   = 4;
  localparam int QIDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_SWITCH  = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_SET     = 2'd3;

  localparam logic [1:0] ST_PAUSED  = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_OTHER   = 2'd2;

  localparam logic [1:0] FAULT_NONE      = 2'd0;
  localparam logic [1:0] FAULT_NO_PAUSED = 2'd1;
  localparam logic [1:0] FAULT_FULL      = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic [PRIORITY_BITS-1:0] pri;
  } q_entry_t;

  localparam int ENTRY_W = $bits(q_entry_t);

endpackage

`default_nettype wire

[sv/prq_ram.sv]
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/priority_ready_queue_scheduler_unit.sv]
// priority ready-queue scheduler: sequencer, thread tables and queue ram
// one item at a time: the input stalls until the result of the last item is
// registered; every queue pass goes through the single read port of the queue
// ram, with a read state and a check or write state per entry; a result waits
// in the output register until taken; rst (synchronous) empties the queue,
// pauses all threads, zeroes their priorities and clears the current
// thread; the queue ram is not cleared
`timescale 1ns / 1ps
`default_nettype none

module priority_ready_queue_scheduler_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] operation,
  input  wire logic [3:0] thread_id,
  input  wire logic [7:0] priority_req,
  input  wire logic [1:0] new_state,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            switched,
  output logic [3:0]      current_thread,
  output logic            current_valid,
  output logic [1:0]      fault
);

  localparam int PW = prq_pkg::PRIORITY_BITS;
  localparam int QW = prq_pkg::QIDX_W;
  localparam int CW = prq_pkg::CNT_W;
  localparam int IW = prq_pkg::ID_W;

  typedef enum logic [11:0] {
    S_IDLE    = 12'h001,
    S_DECODE  = 12'h002,
    S_SWITCH  = 12'h004,
    S_TAIL    = 12'h008,
    S_RM_RD   = 12'h010,
    S_RM_WR   = 12'h020,
    S_INS_BEG = 12'h040,
    S_INS_RD  = 12'h080,
    S_INS_WR  = 12'h100,
    S_TK_RD   = 12'h200,
    S_TK_CHK  = 12'h400,
    S_DONE    = 12'h800
  } state_t;

  function automatic logic [QW-1:0] tix(input logic [IW-1:0] id);
    tix = QW'(id);
  endfunction

  state_t state;

  logic [1:0]    op_r;
  logic [IW-1:0] tgt;
  logic [PW-1:0] pri_r;
  logic [1:0]    ns_r;
  logic          sw_r;
  logic [1:0]    fault_r;

  logic [IW-1:0] w_id;
  logic [PW-1:0] w_pri;
  logic [CW-1:0] i;
  logic          found;
  logic          ins_pending;
  logic          tail;
  logic          tk_paused;

  logic [CW-1:0] count;
  logic [IW-1:0] cur_id;
  logic          present;
  logic [1:0]    thread_states [prq_pkg::MAX_THREADS];
  logic [PW-1:0] thread_prios  [prq_pkg::MAX_THREADS];

  logic              q_we;
  logic [QW-1:0]     q_waddr;
  logic [QW-1:0]     q_raddr;
  prq_pkg::q_entry_t q_wdata;
  prq_pkg::q_entry_t q_rdata;
  prq_pkg::q_entry_t new_entry;

  logic [CW-1:0] i_dec;
  logic [QW-1:0] ts_addr;
  logic [1:0]    ts_rd;
  logic [PW-1:0] cur_pri;
  logic          tid_ok;
  logic          in_take;
  logic          out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign i_dec     = i - CW'(1);
  assign tid_ok    = (32'(tgt) < prq_pkg::MAX_THREADS);
  assign new_entry = '{id: w_id, pri: w_pri};
  assign cur_pri   = thread_prios[tix(cur_id)];
  assign ts_addr   = (state == S_TK_CHK) ? tix(q_rdata.id) : tix(cur_id);
  assign ts_rd     = thread_states[ts_addr];

  prq_ram #(
    .WIDTH(prq_pkg::ENTRY_W),
    .DEPTH(prq_pkg::MAX_THREADS)
  ) u_queue (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .raddr(q_raddr),
    .rdata(q_rdata)
  );

  always_comb begin
    q_we    = 1'b0;
    q_waddr = i[QW-1:0];
    q_wdata = q_rdata;
    q_raddr = i[QW-1:0];
    case (state)
      S_RM_WR: begin
        if (found) begin
          q_we    = 1'b1;
          q_waddr = i_dec[QW-1:0];
        end
      end
      S_INS_RD: begin
        q_raddr = i_dec[QW-1:0];
        if (i == '0) begin
          q_we    = 1'b1;
          q_wdata = new_entry;
        end
      end
      S_INS_WR: begin
        q_we = 1'b1;
        if (!(w_pri < q_rdata.pri)) begin
          q_wdata = new_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cur_id    <= '0;
      present   <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < prq_pkg::MAX_THREADS; k++) begin
        thread_states[k] <= prq_pkg::ST_PAUSED;
        thread_prios[k]  <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            op_r    <= operation;
            tgt     <= thread_id;
            pri_r   <= PW'(priority_req);
            ns_r    <= new_state;
            sw_r    <= 1'b0;
            fault_r <= prq_pkg::FAULT_NONE;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (op_r)
            prq_pkg::OP_ENQUEUE: begin
              if (tid_ok) begin
                thread_prios[tix(tgt)] <= pri_r;
                w_id        <= tgt;
                w_pri       <= pri_r;
                ins_pending <= 1'b1;
                tail        <= 1'b0;
                i           <= '0;
                found       <= 1'b0;
                state       <= S_RM_RD;
              end else begin
                state <= S_DONE;
              end
            end
            prq_pkg::OP_SWITCH: begin
              state <= tid_ok ? S_SWITCH : S_DONE;
            end
            prq_pkg::OP_TICK: begin
              tk_paused <= present && (ts_rd == prq_pkg::ST_PAUSED);
              i         <= '0;
              state     <= S_TK_RD;
            end
            default: begin
              if (tid_ok) begin
                thread_states[tix(tgt)] <= (ns_r > prq_pkg::ST_OTHER) ? prq_pkg::ST_OTHER : ns_r;
              end
              state <= S_DONE;
            end
          endcase
        end
        S_SWITCH: begin
          if (present && cur_id == tgt) begin
            state <= S_DONE;
          end else begin
            sw_r <= 1'b1;
            if (present) begin
              thread_states[tix(cur_id)] <= prq_pkg::ST_PAUSED;
            end
            if (present && ts_rd == prq_pkg::ST_RUNNING) begin
              w_id        <= cur_id;
              w_pri       <= cur_pri;
              ins_pending <= 1'b1;
              tail        <= 1'b1;
              i           <= '0;
              found       <= 1'b0;
              state       <= S_RM_RD;
            end else begin
              state <= S_TAIL;
            end
          end
        end
        S_TAIL: begin
          cur_id                  <= tgt;
          present                 <= 1'b1;
          thread_states[tix(tgt)] <= prq_pkg::ST_RUNNING;
          w_id                    <= tgt;
          ins_pending             <= 1'b0;
          tail                    <= 1'b0;
          i                       <= '0;
          found                   <= 1'b0;
          state                   <= S_RM_RD;
        end
        S_RM_RD: begin
          if (i == count) begin
            if (found) begin
              count <= count - CW'(1);
            end
            if (ins_pending) begin
              state <= S_INS_BEG;
            end else if (tail) begin
              state <= S_TAIL;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_RM_WR;
          end
        end
        S_RM_WR: begin
          if (q_rdata.id == w_id) begin
            found <= 1'b1;
          end
          i     <= i + CW'(1);
          state <= S_RM_RD;
        end
        S_INS_BEG: begin
          if (count >= CW'(prq_pkg::MAX_THREADS)) begin
            fault_r <= prq_pkg::FAULT_FULL;
            state   <= tail ? S_TAIL : S_DONE;
          end else begin
            i     <= count;
            state <= S_INS_RD;
          end
        end
        S_INS_RD: begin
          if (i == '0) begin
            count <= count + CW'(1);
            state <= tail ? S_TAIL : S_DONE;
          end else begin
            state <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          if (w_pri < q_rdata.pri) begin
            i     <= i_dec;
            state <= S_INS_RD;
          end else begin
            count <= count + CW'(1);
            state <= tail ? S_TAIL : S_DONE;
          end
        end
        S_TK_RD: begin
          if (i == count) begin
            if (tk_paused) begin
              fault_r <= prq_pkg::FAULT_NO_PAUSED;
            end
            state <= S_DONE;
          end else begin
            state <= S_TK_CHK;
          end
        end
        S_TK_CHK: begin
          i <= i + CW'(1);
          if (tk_paused) begin
            if (ts_rd == prq_pkg::ST_PAUSED) begin
              tgt   <= q_rdata.id;
              state <= S_SWITCH;
            end else begin
              state <= S_TK_RD;
            end
          end else if (present && q_rdata.id == cur_id) begin
            state <= S_TK_RD;
          end else if (present && q_rdata.pri > cur_pri) begin
            state <= S_DONE;
          end else if (ts_rd == prq_pkg::ST_PAUSED) begin
            tgt   <= q_rdata.id;
            state <= S_SWITCH;
          end else begin
            state <= S_TK_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            switched       <= sw_r;
            current_thread <= cur_id;
            current_valid  <= present;
            fault          <= fault_r;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/prq_checker.sv]
// port-level checks of the scheduler and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

module prq_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       switched,
  input wire logic [3:0] current_thread,
  input wire logic       current_valid,
  input wire logic [1:0] fault
);

  // an accepted beat keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item still in work");

  a_switch_has_current: assert property (@(posedge clk) disable iff (rst)
    out_valid && switched |-> current_valid)
    else $error("switch reported without a current thread");

  a_no_paused_no_switch: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault == prq_pkg::FAULT_NO_PAUSED |-> !switched && current_valid)
    else $error("no-paused fault with switch or without current thread");

  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fault <= prq_pkg::FAULT_FULL)
    else $error("undefined fault code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(current_thread) && $stable(fault))
    else $error("stalled result beat changed");

endmodule

bind priority_ready_queue_scheduler_unit prq_checker u_prq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .switched      (switched),
  .current_thread(current_thread),
  .current_valid (current_valid),
  .fault         (fault)
);

`default_nettype wire

[tb/tb_priority_ready_queue_scheduler_unit.sv]
// self-checking testbench of the priority ready-queue scheduler unit
`timescale 1ns / 1ps

module tb_priority_ready_queue_scheduler_unit;
  import prq_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PRINT_LIMIT  = 200;

  typedef struct packed {
    logic            sw;
    logic [ID_W-1:0] thr;
    logic            vld;
    logic [1:0]      flt;
  } sched_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] operation = OP_ENQUEUE;
  logic [3:0] thread_id = '0;
  logic [7:0] priority_req = '0;
  logic [1:0] new_state = ST_PAUSED;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       switched;
  logic [3:0] current_thread;
  logic       current_valid;
  logic [1:0] fault;

  priority_ready_queue_scheduler_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .thread_id     (thread_id),
    .priority_req  (priority_req),
    .new_state     (new_state),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .switched      (switched),
    .current_thread(current_thread),
    .current_valid (current_valid),
    .fault         (fault)
  );

  // scheduler state mirror
  logic [ID_W-1:0]          rq_id    [MAX_THREADS];
  logic [PRIORITY_BITS-1:0] rq_pri   [MAX_THREADS];
  int                       rq_count;
  logic [1:0]               thr_state[MAX_THREADS];
  logic [PRIORITY_BITS-1:0] thr_pri  [MAX_THREADS];
  logic [ID_W-1:0]          cur_id;
  logic                     cur_on;
  logic [1:0]               step_fault;

  sched_result_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  function automatic int find_queued(logic [ID_W-1:0] id);
    for (int i = 0; i < rq_count; i++)
      if (rq_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void unqueue(logic [ID_W-1:0] id);
    int pos;
    pos = find_queued(id);
    if (pos < 0) return;
    for (int i = pos; i + 1 < rq_count; i++) begin
      rq_id[i]  = rq_id[i+1];
      rq_pri[i] = rq_pri[i+1];
    end
    rq_count--;
  endfunction

  function automatic logic [1:0] enqueue_sorted(logic [ID_W-1:0] id,
                                                logic [PRIORITY_BITS-1:0] pri);
    int pos;
    unqueue(id);
    if (rq_count >= MAX_THREADS) return FAULT_FULL;
    pos = rq_count;
    for (int i = 0; i < rq_count; i++) begin
      if (pri < rq_pri[i]) begin
        pos = i;
        break;
      end
    end
    for (int i = rq_count; i > pos; i--) begin
      rq_id[i]  = rq_id[i-1];
      rq_pri[i] = rq_pri[i-1];
    end
    rq_id[pos]  = id;
    rq_pri[pos] = pri;
    rq_count++;
    return FAULT_NONE;
  endfunction

  function automatic logic switch_to(logic [ID_W-1:0] target);
    if (cur_on && cur_id == target) return 1'b0;
    if (cur_on) begin
      if (thr_state[cur_id] == ST_RUNNING)
        step_fault = enqueue_sorted(cur_id, thr_pri[cur_id]);
      thr_state[cur_id] = ST_PAUSED;
    end
    cur_id = target;
    cur_on = 1'b1;
    thr_state[target] = ST_RUNNING;
    unqueue(target);
    return 1'b1;
  endfunction

  function automatic logic run_tick();
    logic [ID_W-1:0] id;
    if (cur_on && thr_state[cur_id] == ST_PAUSED) begin
      for (int i = 0; i < rq_count; i++)
        if (thr_state[rq_id[i]] == ST_PAUSED) return switch_to(rq_id[i]);
      step_fault = FAULT_NO_PAUSED;
      return 1'b0;
    end
    for (int i = 0; i < rq_count; i++) begin
      id = rq_id[i];
      if (cur_on && id == cur_id) continue;
      if (cur_on && rq_pri[i] > thr_pri[cur_id]) return 1'b0;
      if (thr_state[id] == ST_PAUSED) return switch_to(id);
    end
    return 1'b0;
  endfunction

  function automatic sched_result_t predict_beat(logic [1:0] op, logic [3:0] tid,
                                                 logic [7:0] pri, logic [1:0] ns);
    sched_result_t r;
    logic sw;
    logic tid_ok;
    sw = 1'b0;
    step_fault = FAULT_NONE;
    tid_ok = int'(tid) < MAX_THREADS;
    case (op)
      OP_ENQUEUE: begin
        if (tid_ok) begin
          thr_pri[tid] = pri[PRIORITY_BITS-1:0];
          step_fault = enqueue_sorted(tid, pri[PRIORITY_BITS-1:0]);
        end
      end
      OP_SWITCH: begin
        if (tid_ok) sw = switch_to(tid);
      end
      OP_TICK: begin
        sw = run_tick();
      end
      default: begin
        if (tid_ok) thr_state[tid] = (ns > ST_OTHER) ? ST_OTHER : ns;
      end
    endcase
    r.sw  = sw;
    r.thr = cur_id;
    r.vld = cur_on;
    r.flt = step_fault;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // one input beat, predicted at the edge that accepts it
  task automatic send_beat(logic [1:0] op, logic [3:0] tid, logic [7:0] pri,
                           logic [1:0] ns);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? pick_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    thread_id    <= tid;
    priority_req <= pri;
    new_state    <= ns;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_beat(op, tid, pri, ns));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_enqueue_order();
    send_beat(OP_TICK, 4'd0, 8'd0, ST_PAUSED);
    send_beat(OP_ENQUEUE, 4'd3, 8'd10, ST_PAUSED);
    send_beat(OP_ENQUEUE, 4'd7, 8'd10, 2'd3);
    send_beat(OP_ENQUEUE, 4'd15, 8'hff, ST_RUNNING);
    send_beat(OP_ENQUEUE, 4'd0, 8'd0, ST_OTHER);
    send_beat(OP_ENQUEUE, 4'd3, 8'd0, ST_PAUSED);
    send_beat(OP_TICK, 4'hf, 8'hff, 2'd3);
    wait_idle();
  endtask

  task automatic test_switch_and_tick();
    send_beat(OP_SWITCH, 4'd0, 8'h55, ST_PAUSED);
    send_beat(OP_TICK, 4'd9, 8'haa, ST_RUNNING);
    send_beat(OP_SWITCH, 4'd12, 8'd0, ST_PAUSED);
    send_beat(OP_ENQUEUE, 4'd12, 8'd200, ST_PAUSED);
    send_beat(OP_TICK, 4'd0, 8'd0, ST_PAUSED);
    send_beat(OP_SET, 4'd5, 8'd0, 2'd3);
    send_beat(OP_SET, 4'd7, 8'hff, ST_RUNNING);
    wait_idle();
  endtask

  task automatic test_paused_fault();
    logic [ID_W-1:0] fresh;
    fresh = '0;
    for (int i = 0; i < MAX_THREADS; i++)
      if (find_queued(i[ID_W-1:0]) < 0 && !(cur_on && cur_id == i[ID_W-1:0]))
        fresh = i[ID_W-1:0];
    send_beat(OP_SWITCH, fresh, 8'd1, ST_OTHER);
    for (int i = 0; i < rq_count; i++)
      send_beat(OP_SET, rq_id[i], 8'd0, ST_OTHER);
    send_beat(OP_SET, fresh, 8'd0, ST_PAUSED);
    send_beat(OP_TICK, 4'd0, 8'd0, ST_PAUSED);
    if (rq_count > 0) send_beat(OP_SET, rq_id[rq_count-1], 8'd0, ST_PAUSED);
    send_beat(OP_TICK, 4'd0, 8'd0, ST_PAUSED);
    wait_idle();
  endtask

  function automatic logic [7:0] pick_pri();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(0, 3));
    if (r < 50) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_random_mix(int n, int gap_p, int stall_p);
    int sent;
    int r;
    int base;
    int step;
    logic [1:0] op;
    logic [3:0] tid;
    logic [1:0] ns;
    gap_pct   = gap_p;
    stall_pct = stall_p;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // fill the queue with every thread in a scrambled order
        base = $urandom_range(0, 15);
        step = 2 * $urandom_range(0, 7) + 1;
        for (int k = 0; k < MAX_THREADS; k++)
          send_beat(OP_ENQUEUE, 4'((base + k * step) % MAX_THREADS), pick_pri(),
                    2'($urandom_range(0, 3)));
        sent += MAX_THREADS;
      end else begin
        r   = $urandom_range(0, 99);
        tid = 4'($urandom_range(0, 15));
        ns  = 2'($urandom_range(0, 3));
        if (r < 35) op = OP_ENQUEUE;
        else if (r < 60) op = OP_TICK;
        else if (r < 78) op = OP_SWITCH;
        else op = OP_SET;
        if (op == OP_SWITCH && rq_count > 0 && $urandom_range(0, 1))
          tid = rq_id[$urandom_range(0, rq_count - 1)];
        if (op == OP_SET && $urandom_range(0, 1)) ns = ST_PAUSED;
        send_beat(op, tid, pick_pri(), ns);
        sent++;
      end
    end
    wait_idle();
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
          $display("%0t: result with nothing expected, actual sw %0d thread %0d valid %0d fault %0d",
                   $time, switched, current_thread, current_valid, fault);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("switched", exp_r.sw, switched);
        check_field("current_thread", exp_r.thr, current_thread);
        check_field("current_valid", exp_r.vld, current_valid);
        check_field("fault", exp_r.flt, fault);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 99) < stall_pct);
      stall_left <= pick_len() - 1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rq_count = 0;
    cur_id   = '0;
    cur_on   = 1'b0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      rq_id[i]     = '0;
      rq_pri[i]    = '0;
      thr_state[i] = ST_PAUSED;
      thr_pri[i]   = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_enqueue_order();
    test_switch_and_tick();
    test_paused_fault();
    test_random_mix(150, 0, 0);
    test_random_mix(150, 25, 25);
    test_random_mix(150, 10, 60);
    test_random_mix(150, 60, 10);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[priority_ready_queue_scheduler_unit.f]
sv/prq_pkg.sv
sv/prq_ram.sv
sv/priority_ready_queue_scheduler_unit.sv
sv/prq_checker.sv
tb/tb_priority_ready_queue_scheduler_unit.sv
